### design/symmetry_point_mirror_macros.svh
// ----------------------------------------------------------------------------
// Symmetry point mirror assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SYMMETRY_POINT_MIRROR_MACROS_SVH
`define SYMMETRY_POINT_MIRROR_MACROS_SVH

// same-cycle implication
`define SMP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smp: assertion failed");

// next-cycle implication
`define SMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smp: assertion failed");

`endif

### design/smp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_pkg
// Types, widths and codes shared by the symmetry point mirror modules.
// ----------------------------------------------------------------------------
package smp_pkg;

    localparam int COORD_BITS    = 16;
    localparam int AXIS_BITS     = 16;
    localparam int SIZE_BITS     = 9;
    localparam int CENTER_BITS   = 8;
    localparam int MODE_BITS     = 4;
    localparam int SRC_BITS      = 2;
    localparam int SYM_BITS      = 3;
    localparam int NUM_SYM       = 8;
    localparam int SLOT_BITS     = 3;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int DEF_MAX_BRUSH = 256;
    // 2*centre - size for sizes up to 1024
    localparam int OFS_BITS      = 12;
    localparam int WIDE_BITS     = ((COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS) + 4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE_MASK      = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_X_HALF    = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_Y_HALF    = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_WIDTH    = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_HEIGHT   = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_CENTER_X = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_CENTER_Y = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRUSH_SOURCE   = 4'd7;

    // brush sources
    localparam logic [SRC_BITS-1:0] SRC_FIXED   = 2'd0;
    localparam logic [SRC_BITS-1:0] SRC_DYNAMIC = 2'd1;
    localparam logic [SRC_BITS-1:0] SRC_FLOOD   = 2'd2;

    // mode masks with their own copy order
    localparam logic [MODE_BITS-1:0] MODE_NONE  = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_H     = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_V     = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_HV    = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_RDIAG = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_LDIAG = 4'd8;
    localparam logic [MODE_BITS-1:0] MODE_DIAG  = 4'd12;

    typedef enum logic [SYM_BITS-1:0] {
        SYM_IDENTITY   = 3'd0,
        SYM_FLIPX      = 3'd1,
        SYM_FLIPY      = 3'd2,
        SYM_FLIPXY     = 3'd3,
        SYM_ROTFLIP90  = 3'd4,
        SYM_ROTFLIP270 = 3'd5,
        SYM_ROT90      = 3'd6,
        SYM_ROT270     = 3'd7
    } sym_code_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [SIZE_BITS-1:0]         point_size;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic [SIZE_BITS-1:0]         out_size;
        logic [SYM_BITS-1:0]          symmetry_code;
        logic                         last_copy;
    } result_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode_mask;
        logic [AXIS_BITS-1:0]   axis_x_half;
        logic [AXIS_BITS-1:0]   axis_y_half;
        logic [SIZE_BITS-1:0]   brush_width;
        logic [SIZE_BITS-1:0]   brush_height;
        logic [CENTER_BITS-1:0] brush_center_x;
        logic [CENTER_BITS-1:0] brush_center_y;
        logic [SRC_BITS-1:0]    brush_source;
    } cfg_t;

    // after brush selection
    typedef struct packed {
        logic [COORD_BITS-1:0]      x;
        logic [COORD_BITS-1:0]      y;
        logic [SIZE_BITS-1:0]       size;
        logic [MODE_BITS-1:0]       mode;
        logic [AXIS_BITS-1:0]       ax;
        logic [AXIS_BITS-1:0]       ay;
        logic signed [OFS_BITS-1:0] kx;
        logic signed [OFS_BITS-1:0] ky;
        logic                       pw_r;
        logic                       ph_r;
    } s1_t;

    // after the half-pixel sums
    typedef struct packed {
        logic [COORD_BITS-1:0]       x;
        logic [COORD_BITS-1:0]       y;
        logic [SIZE_BITS-1:0]        size;
        logic [MODE_BITS-1:0]        mode;
        logic [COORD_BITS-1:0]       fx;
        logic [COORD_BITS-1:0]       fy;
        logic signed [WIDE_BITS-1:0] n4x;
        logic signed [WIDE_BITS-1:0] n4y;
        logic signed [WIDE_BITS-1:0] n5x;
        logic signed [WIDE_BITS-1:0] n5y;
        logic [AXIS_BITS-1:0]        ay;
        logic                        ph_r;
    } s2_t;

    // all eight copies, indexed by symmetry code
    typedef struct packed {
        logic [SIZE_BITS-1:0]                 size;
        logic [MODE_BITS-1:0]                 mode;
        logic [NUM_SYM-1:0][COORD_BITS-1:0]   xs;
        logic [NUM_SYM-1:0][COORD_BITS-1:0]   ys;
    } copies_t;

endpackage

### design/smp_brush.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_brush
// First stage: clamps brush sizes and picks the per-copy brush offsets.
// ----------------------------------------------------------------------------
module smp_brush
    import smp_pkg::*;
#(
    parameter int MAX_BRUSH = DEF_MAX_BRUSH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   point_valid,
    output logic   point_ready,
    input  point_t point,
    output logic   s1_valid,
    input  logic   s1_ready,
    output s1_t    s1
);

    localparam int SZ_W  = $clog2(MAX_BRUSH + 1);
    localparam int CMP_W = (SZ_W > SIZE_BITS) ? SZ_W : SIZE_BITS;

    function automatic logic [CMP_W-1:0] clamp_size(input logic [SIZE_BITS-1:0] s);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(s);
        if (ext == '0)
            clamp_size = CMP_W'(1);
        else if (ext > CMP_W'(MAX_BRUSH))
            clamp_size = CMP_W'(MAX_BRUSH);
        else
            clamp_size = ext;
    endfunction

    logic [CMP_W-1:0]           bw_c;
    logic [CMP_W-1:0]           bh_c;
    logic [CMP_W-1:0]           ps_c;
    logic signed [OFS_BITS-1:0] kx_fixed;
    logic signed [OFS_BITS-1:0] ky_fixed;
    s1_t                        s1_next;
    logic                       s1_valid_reg;
    s1_t                        s1_reg;

    assign bw_c = clamp_size(cfg.brush_width);
    assign bh_c = clamp_size(cfg.brush_height);
    assign ps_c = clamp_size(point.point_size);

    assign kx_fixed = $signed(OFS_BITS'({cfg.brush_center_x, 1'b0})) - $signed(OFS_BITS'(bw_c));
    assign ky_fixed = $signed(OFS_BITS'({cfg.brush_center_y, 1'b0})) - $signed(OFS_BITS'(bh_c));

    always_comb
    begin
        s1_next.x    = point.point_x;
        s1_next.y    = point.point_y;
        s1_next.size = point.point_size;
        s1_next.mode = cfg.mode_mask;
        s1_next.ax   = cfg.axis_x_half;
        s1_next.ay   = cfg.axis_y_half;
        unique case (cfg.brush_source)
            SRC_DYNAMIC:
            begin
                // 2*(w/2) - w is minus the low bit of w
                s1_next.kx   = {OFS_BITS{ps_c[0]}};
                s1_next.ky   = {OFS_BITS{ps_c[0]}};
                s1_next.pw_r = ps_c[0];
                s1_next.ph_r = ps_c[0];
            end
            SRC_FLOOD:
            begin
                s1_next.kx   = '1;
                s1_next.ky   = '1;
                s1_next.pw_r = 1'b1;
                s1_next.ph_r = 1'b1;
            end
            default:
            begin
                // fixed brush; rotating copies swap width and height
                s1_next.kx   = kx_fixed;
                s1_next.ky   = ky_fixed;
                s1_next.pw_r = bh_c[0];
                s1_next.ph_r = bw_c[0];
            end
        endcase
    end

    assign point_ready = !s1_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (point_ready)
            s1_valid_reg <= point_valid;
    end

    always_ff @(posedge clk)
    begin
        if (point_valid && point_ready)
            s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

### design/smp_mirror.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_mirror
// Second and third stages: half-pixel sums, halving toward zero, and the
// eight mirrored copies of the point.
// ----------------------------------------------------------------------------
module smp_mirror
    import smp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s1_valid,
    output logic    s1_ready,
    input  s1_t     s1,
    output logic    copies_valid,
    input  logic    copies_ready,
    output copies_t copies
);

    localparam int W = WIDE_BITS;

    function automatic logic signed [W-1:0] halve(input logic signed [W-1:0] v);
        logic signed [W-1:0] t;
        t = v + $signed(W'(v[W-1]));
        halve = t >>> 1;
    endfunction

    // stage 2
    logic signed [W-1:0] px_w;
    logic signed [W-1:0] py_w;
    logic signed [W-1:0] ax_w;
    logic signed [W-1:0] ay_w;
    logic signed [W-1:0] kx_w;
    logic signed [W-1:0] ky_w;
    logic signed [W-1:0] ax_odd_w;
    logic signed [W-1:0] ay_odd_w;
    logic signed [W-1:0] pw2_w;
    logic signed [W-1:0] ph2_w;
    logic signed [W-1:0] ajx2_w;
    logic signed [W-1:0] ajy2_w;
    logic signed [W-1:0] fx_w;
    logic signed [W-1:0] fy_w;
    s2_t                 s2_next;
    s2_t                 s2_reg;
    logic                s2_valid_reg;
    logic                s2_ready;

    // stage 3
    logic signed [W-1:0] h4x;
    logic signed [W-1:0] h4y;
    logic signed [W-1:0] h5x;
    logic signed [W-1:0] h5y;
    logic signed [W-1:0] ay3_w;
    logic signed [W-1:0] ph3_w;
    logic signed [W-1:0] r7y;
    logic signed [W-1:0] r6y;
    copies_t             s3_next;
    copies_t             s3_reg;
    logic                s3_valid_reg;

    assign px_w     = {{(W-COORD_BITS){s1.x[COORD_BITS-1]}}, s1.x};
    assign py_w     = {{(W-COORD_BITS){s1.y[COORD_BITS-1]}}, s1.y};
    assign ax_w     = {{(W-AXIS_BITS){1'b0}}, s1.ax};
    assign ay_w     = {{(W-AXIS_BITS){1'b0}}, s1.ay};
    assign kx_w     = {{(W-OFS_BITS){s1.kx[OFS_BITS-1]}}, s1.kx};
    assign ky_w     = {{(W-OFS_BITS){s1.ky[OFS_BITS-1]}}, s1.ky};
    assign ax_odd_w = {{(W-1){1'b0}}, s1.ax[0]};
    assign ay_odd_w = {{(W-1){1'b0}}, s1.ay[0]};
    assign pw2_w    = {{(W-2){1'b0}}, s1.pw_r, 1'b0};
    assign ph2_w    = {{(W-2){1'b0}}, s1.ph_r, 1'b0};
    // half-pixel adjustment is dropped when both axes are odd
    assign ajx2_w   = {{(W-2){1'b0}}, s1.ay[0] & ~s1.ax[0], 1'b0};
    assign ajy2_w   = {{(W-2){1'b0}}, s1.ax[0] & ~s1.ay[0], 1'b0};

    assign fx_w = ax_w + kx_w - px_w;
    assign fy_w = ay_w + ky_w - py_w;

    always_comb
    begin
        s2_next.x    = s1.x;
        s2_next.y    = s1.y;
        s2_next.size = s1.size;
        s2_next.mode = s1.mode;
        s2_next.fx   = fx_w[COORD_BITS-1:0];
        s2_next.fy   = fy_w[COORD_BITS-1:0];
        s2_next.n4x  = py_w + py_w + ax_w - ay_w + ax_odd_w;
        s2_next.n4y  = px_w + px_w - ax_w + ay_w + ay_odd_w;
        s2_next.n5x  = ax_w + ay_w - py_w - py_w - pw2_w + ajx2_w;
        s2_next.n5y  = ax_w + ay_w - px_w - px_w - ph2_w + ajy2_w;
        s2_next.ay   = s1.ay;
        s2_next.ph_r = s1.ph_r;
    end

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign s2_ready = !s3_valid_reg || copies_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s2_valid_reg <= s1_valid;
            if (s2_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready)
            s2_reg <= s2_next;
        if (s2_valid_reg && s2_ready)
            s3_reg <= s3_next;
    end

    assign h4x   = halve(s2_reg.n4x);
    assign h4y   = halve(s2_reg.n4y);
    assign h5x   = halve(s2_reg.n5x);
    assign h5y   = halve(s2_reg.n5y);
    assign ay3_w = {{(W-AXIS_BITS){1'b0}}, s2_reg.ay};
    assign ph3_w = {{(W-1){1'b0}}, s2_reg.ph_r};
    assign r7y   = ay3_w - h4y - ph3_w;
    assign r6y   = ay3_w - h5y - ph3_w;

    always_comb
    begin
        s3_next.size = s2_reg.size;
        s3_next.mode = s2_reg.mode;
        s3_next.xs[SYM_IDENTITY]   = s2_reg.x;
        s3_next.ys[SYM_IDENTITY]   = s2_reg.y;
        s3_next.xs[SYM_FLIPX]      = s2_reg.fx;
        s3_next.ys[SYM_FLIPX]      = s2_reg.y;
        s3_next.xs[SYM_FLIPY]      = s2_reg.x;
        s3_next.ys[SYM_FLIPY]      = s2_reg.fy;
        s3_next.xs[SYM_FLIPXY]     = s2_reg.fx;
        s3_next.ys[SYM_FLIPXY]     = s2_reg.fy;
        s3_next.xs[SYM_ROTFLIP90]  = h4x[COORD_BITS-1:0];
        s3_next.ys[SYM_ROTFLIP90]  = h4y[COORD_BITS-1:0];
        s3_next.xs[SYM_ROT270]     = h4x[COORD_BITS-1:0];
        s3_next.ys[SYM_ROT270]     = r7y[COORD_BITS-1:0];
        s3_next.xs[SYM_ROTFLIP270] = h5x[COORD_BITS-1:0];
        s3_next.ys[SYM_ROTFLIP270] = h5y[COORD_BITS-1:0];
        s3_next.xs[SYM_ROT90]      = h5x[COORD_BITS-1:0];
        s3_next.ys[SYM_ROT90]      = r6y[COORD_BITS-1:0];
    end

    assign copies_valid = s3_valid_reg;
    assign copies       = s3_reg;

endmodule

### design/smp_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_serial
// Holds one point's copies and sends them out one per transaction, in the
// order the mode mask calls for.
// ----------------------------------------------------------------------------
module smp_serial
    import smp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    copies_valid,
    output logic    copies_ready,
    input  copies_t copies,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    function automatic logic [SLOT_BITS-1:0] last_slot(input logic [MODE_BITS-1:0] mode);
        unique case (mode)
            MODE_NONE:                               last_slot = 3'd0;
            MODE_H, MODE_V, MODE_RDIAG, MODE_LDIAG: last_slot = 3'd1;
            MODE_HV, MODE_DIAG:                      last_slot = 3'd3;
            default:                                 last_slot = 3'd7;
        endcase
    endfunction

    function automatic sym_code_t code_at(input logic [MODE_BITS-1:0] mode,
                                          input logic [SLOT_BITS-1:0] slot);
        code_at = SYM_IDENTITY;
        unique case (mode)
            MODE_NONE:  code_at = SYM_IDENTITY;
            MODE_H:     code_at = (slot == '0) ? SYM_IDENTITY : SYM_FLIPX;
            MODE_V:     code_at = (slot == '0) ? SYM_IDENTITY : SYM_FLIPY;
            MODE_RDIAG: code_at = (slot == '0) ? SYM_IDENTITY : SYM_ROTFLIP270;
            MODE_LDIAG: code_at = (slot == '0) ? SYM_IDENTITY : SYM_ROTFLIP90;
            MODE_HV:
            begin
                unique case (slot)
                    3'd0:    code_at = SYM_IDENTITY;
                    3'd1:    code_at = SYM_FLIPX;
                    3'd2:    code_at = SYM_FLIPY;
                    default: code_at = SYM_FLIPXY;
                endcase
            end
            MODE_DIAG:
            begin
                unique case (slot)
                    3'd0:    code_at = SYM_IDENTITY;
                    3'd1:    code_at = SYM_ROTFLIP270;
                    3'd2:    code_at = SYM_ROTFLIP90;
                    default: code_at = SYM_FLIPXY;
                endcase
            end
            default:
            begin
                unique case (slot)
                    3'd0:    code_at = SYM_IDENTITY;
                    3'd1:    code_at = SYM_FLIPX;
                    3'd2:    code_at = SYM_FLIPY;
                    3'd3:    code_at = SYM_FLIPXY;
                    3'd4:    code_at = SYM_ROTFLIP90;
                    3'd5:    code_at = SYM_ROT270;
                    3'd6:    code_at = SYM_ROTFLIP270;
                    default: code_at = SYM_ROT90;
                endcase
            end
        endcase
    endfunction

    logic                 busy_reg;
    logic [SLOT_BITS-1:0] idx_reg;
    copies_t              item_reg;
    logic                 last;
    sym_code_t            code;

    assign last         = (idx_reg == last_slot(item_reg.mode));
    assign code         = code_at(item_reg.mode, idx_reg);
    assign copies_ready = !busy_reg || (result_ready && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (copies_valid && copies_ready)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (result_valid && result_ready)
        begin
            if (last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (copies_valid && copies_ready)
            item_reg <= copies;
    end

    assign result_valid         = busy_reg;
    assign result.out_x         = item_reg.xs[code];
    assign result.out_y         = item_reg.ys[code];
    assign result.out_size      = item_reg.size;
    assign result.symmetry_code = code;
    assign result.last_copy     = last;

endmodule

### design/symmetry_point_mirror.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetry_point_mirror
// Emits each stroke point followed by its mirrored copies.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*    : register writes, always ready; write only while the block is
//              idle. Indexes past the last register are ignored.
//   point_*  : one stroke point per transaction.
//   result_* : the identity copy first, then the mirrored copies, with
//              last_copy set on the final one.
// Path: an accepted point passes three pipeline registers, then the output
//   holding register, before its first result shows.
// Throughput: the output register sends one copy per cycle while result_ready
//   is high, and a point has 1, 2, 4 or 8 copies by mode mask; points enter one
//   per cycle behind it, and up to three more are buffered in the pipeline.
// Reset: clears all valid bits and loads the register defaults (mode 0,
//   brush 1x1, centre 0, fixed brush).
// Stall: when result_ready is low the current copy holds; the pipeline fills
//   and then point_ready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module symmetry_point_mirror
    import smp_pkg::*;
#(
    parameter int MAX_BRUSH = DEF_MAX_BRUSH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     point_valid,
    output logic                     point_ready,
    input  point_t                   point,
    output logic                     result_valid,
    input  logic                     result_ready,
    output result_t                  result
);

    cfg_t    cfg_reg;
    logic    s1_valid;
    logic    s1_ready;
    s1_t     s1;
    logic    copies_valid;
    logic    copies_ready;
    copies_t copies;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_mask      <= '0;
            cfg_reg.axis_x_half    <= '0;
            cfg_reg.axis_y_half    <= '0;
            cfg_reg.brush_width    <= SIZE_BITS'(1);
            cfg_reg.brush_height   <= SIZE_BITS'(1);
            cfg_reg.brush_center_x <= '0;
            cfg_reg.brush_center_y <= '0;
            cfg_reg.brush_source   <= SRC_FIXED;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE_MASK:      cfg_reg.mode_mask      <= cfg_data[MODE_BITS-1:0];
                REG_AXIS_X_HALF:    cfg_reg.axis_x_half    <= cfg_data[AXIS_BITS-1:0];
                REG_AXIS_Y_HALF:    cfg_reg.axis_y_half    <= cfg_data[AXIS_BITS-1:0];
                REG_BRUSH_WIDTH:    cfg_reg.brush_width    <= cfg_data[SIZE_BITS-1:0];
                REG_BRUSH_HEIGHT:   cfg_reg.brush_height   <= cfg_data[SIZE_BITS-1:0];
                REG_BRUSH_CENTER_X: cfg_reg.brush_center_x <= cfg_data[CENTER_BITS-1:0];
                REG_BRUSH_CENTER_Y: cfg_reg.brush_center_y <= cfg_data[CENTER_BITS-1:0];
                REG_BRUSH_SOURCE:   cfg_reg.brush_source   <= cfg_data[SRC_BITS-1:0];
                default:            ;
            endcase
        end
    end

    smp_brush #(
        .MAX_BRUSH (MAX_BRUSH)
    ) u_brush (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1          (s1)
    );

    smp_mirror u_mirror (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1           (s1),
        .copies_valid (copies_valid),
        .copies_ready (copies_ready),
        .copies       (copies)
    );

    smp_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .copies_valid (copies_valid),
        .copies_ready (copies_ready),
        .copies       (copies),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### design/smp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smp_checker
// Port-level checks on the symmetry point mirror result channel.
// ----------------------------------------------------------------------------
`include "symmetry_point_mirror_macros.svh"

module smp_checker
    import smp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    logic mid_copy;

    assign mid_copy = result_valid && result_ready && !result.last_copy;

    // stalled result holds
    `SMP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
    // copies of one point come back to back
    `SMP_ASSERT_NEXT(a_copies_contiguous, mid_copy, result_valid)
    // only the first copy of a point is the identity
    `SMP_ASSERT_NEXT(a_identity_first, mid_copy, result.symmetry_code != SYM_IDENTITY)
    // all copies of a point carry its size
    `SMP_ASSERT_NEXT(a_size_kept, mid_copy, result.out_size == $past(result.out_size))

endmodule

bind symmetry_point_mirror smp_checker u_smp_checker (.*);
